// ===== hdl/wtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Wavetable phase-to-amplitude: shared constants and table functions
// Mode codes, sample limits, the half-wave shape table and the builder for
// the quarter-wave sine table. The sine builder runs at elaboration only.
// ----------------------------------------------------------------------------
package wtp_pkg;

   localparam logic [2:0] MODE_SINE_LERP  = 3'd0;
   localparam logic [2:0] MODE_SINE       = 3'd1;
   localparam logic [2:0] MODE_TRIANGLE   = 3'd2;
   localparam logic [2:0] MODE_SQUARE     = 3'd3;
   localparam logic [2:0] MODE_RAMP_UP    = 3'd4;
   localparam logic [2:0] MODE_RAMP_DOWN  = 3'd5;
   localparam logic [2:0] MODE_SHAPE_LERP = 3'd6;
   localparam logic [2:0] MODE_UNUSED     = 3'd7;

   localparam logic signed [16:0] SAMPLE_MAX = 17'sd32767;
   localparam logic signed [16:0] SAMPLE_MIN = -17'sd32768;

   localparam int unsigned SHAPE_LAST = 16;

   localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
   localparam logic [63:0] ONE_Q31     = 64'h0000_0000_8000_0000;
   localparam logic [63:0] HALF_Q31    = 64'h0000_0000_4000_0000;

   // k*(k+1) for k = 18, 16, ..., 2 of the nested Taylor series
   localparam logic [63:0] TAYLOR_DIV [9] = '{
      64'd342, 64'd272, 64'd210, 64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
   };

   // Entry idx of a quarter-wave table of 2^log2+1 entries, built from
   // integer Q31 arithmetic: round(32767*sin(idx*pi/2^(log2+1))).
   function automatic logic [14:0] sine_rom_value(input int unsigned log2,
                                                  input int unsigned idx);
      logic [63:0] step;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] v;
      step = HALF_PI_Q62 >> log2;
      x    = ((step * 64'(idx)) + HALF_Q31) >> 31;
      x2   = (x * x) >> 31;
      t    = ONE_Q31;
      for (int j = 0; j < 9; j++) begin
         p = ((x2 * t) >> 31) / TAYLOR_DIV[j];
         t = (p >= ONE_Q31) ? 64'd0 : ONE_Q31 - p;
      end
      s = (x * t) >> 31;
      v = ((64'd32767 * s) + HALF_Q31) >> 31;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

   // Half-wave shape table; indices past the last entry saturate.
   function automatic logic [14:0] shape_rom_value(input logic [8:0] idx);
      logic [4:0]  sat;
      logic [14:0] val;
      sat = (idx > 9'(SHAPE_LAST)) ? 5'(SHAPE_LAST) : idx[4:0];
      unique case (sat)
         5'd0:    val = 15'd0;
         5'd1:    val = 15'd10;
         5'd2:    val = 15'd1000;
         5'd3:    val = 15'd2000;
         5'd4:    val = 15'd10000;
         5'd5:    val = 15'd12000;
         5'd6:    val = 15'd20000;
         5'd7:    val = 15'd25000;
         5'd8:    val = 15'd32000;
         5'd9:    val = 15'd32200;
         5'd10:   val = 15'd32000;
         5'd11:   val = 15'd25000;
         5'd12:   val = 15'd20000;
         5'd13:   val = 15'd12000;
         5'd14:   val = 15'd10000;
         5'd15:   val = 15'd1000;
         5'd16:   val = 15'd10;
         default: val = 15'd10;
      endcase
      return val;
   endfunction

endpackage

// ===== hdl/wavetable_phase_to_amplitude.sv =====
// ----------------------------------------------------------------------------
// Wavetable phase-to-amplitude converter
// Maps a 32-bit oscillator phase to a signed 16-bit sample for seven
// waveforms: quarter-wave sine (plain and interpolated), triangle, square,
// two ramps and an interpolated half-wave shape.
// ----------------------------------------------------------------------------
//
//  Channel    Ports                          Transfer
//  ---------  -----------------------------  ----------------------------------
//  request    start, busy, req_mode,         edge with start high and busy low
//             req_phase
//  response   rsp_valid, rsp_sample          edge ending the cycle rsp_valid
//                                            is high; one cycle only
//
//  One request is taken every cycle; busy is always low. Each sample passes
//  in order through the input register, table address, table read,
//  interpolation multiply, and final add and output register.
//  Reset clears the valid bits of every stage; data in flight is dropped.
//  The receiver takes every response, so the pipeline never stalls.
//
module wavetable_phase_to_amplitude #(
   parameter int SINE_TABLE_LOG2  = 7,
   parameter int SHAPE_TABLE_LOG2 = 4,
   parameter int FRACTION_BITS    = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_mode,
   input  logic [31:0]        req_phase,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_sample
);
   import wtp_pkg::*;

   localparam int SINE_N   = 1 << SINE_TABLE_LOG2;
   localparam int SINE_AW  = SINE_TABLE_LOG2 + 1;
   localparam int SINE_IW  = SINE_TABLE_LOG2 + 2;
   localparam int SHAPE_N  = 1 << SHAPE_TABLE_LOG2;
   localparam int SHAPE_AW = SHAPE_TABLE_LOG2 + 1;
   localparam int SHAPE_IW = SHAPE_TABLE_LOG2 + 1;
   localparam int FW       = FRACTION_BITS;
   localparam int PW       = 18 + FRACTION_BITS;

   localparam logic [1:0] KIND_FLAT  = 2'd0;
   localparam logic [1:0] KIND_SINE  = 2'd1;
   localparam logic [1:0] KIND_SHAPE = 2'd2;

   // Quarter-wave sine table, fixed at elaboration
   logic [14:0] sine_rom [SINE_N + 1];

   for (genvar g = 0; g <= SINE_N; g++) begin : g_sine_rom
      assign sine_rom[g] = sine_rom_value(SINE_TABLE_LOG2, g);
   end

   function automatic logic [SINE_AW-1:0] sine_addr(input logic [SINE_IW-1:0] idx);
      logic [SINE_AW-1:0] pos;
      pos = {1'b0, idx[SINE_TABLE_LOG2-1:0]};
      return idx[SINE_TABLE_LOG2] ? SINE_AW'(SINE_N) - pos : pos;
   endfunction

   function automatic logic [SHAPE_AW-1:0] shape_addr(input logic [SHAPE_IW-1:0] idx);
      logic [SHAPE_AW-1:0] pos;
      pos = {1'b0, idx[SHAPE_TABLE_LOG2-1:0]};
      return idx[SHAPE_TABLE_LOG2] ? SHAPE_AW'(SHAPE_N) - pos : pos;
   endfunction

   // ---- stage 0: input register ----
   logic        in_vld_ff;
   logic [2:0]  in_mode_ff;
   logic [31:0] in_phase_ff;

   // ---- stage 1: table addresses ----
   logic                     ad_vld_ff;
   logic [1:0]               ad_kind_ff,     ad_kind_in;
   logic [SINE_AW-1:0]       ad_sin_a_ff,    ad_sin_a_in;
   logic [SINE_AW-1:0]       ad_sin_b_ff,    ad_sin_b_in;
   logic [SHAPE_AW-1:0]      ad_shp_a_ff,    ad_shp_a_in;
   logic [SHAPE_AW-1:0]      ad_shp_b_ff,    ad_shp_b_in;
   logic                     ad_neg_a_ff,    ad_neg_a_in;
   logic                     ad_neg_b_ff,    ad_neg_b_in;
   logic [FW-1:0]            ad_frac_ff,     ad_frac_in;
   logic signed [16:0]       ad_flat_ff,     ad_flat_in;

   logic [SINE_IW-1:0]       sin_a, sin_b;
   logic [SHAPE_IW-1:0]      shp_a, shp_b;
   logic [14:0]              tri_q;
   logic [15:0]              ramp_hi;

   always_comb begin
      sin_a   = in_phase_ff[31 -: SINE_IW];
      sin_b   = sin_a + 1'b1;
      shp_a   = in_phase_ff[31 -: SHAPE_IW];
      shp_b   = shp_a + 1'b1;
      tri_q   = in_phase_ff[29:15];
      ramp_hi = in_phase_ff[31:16];

      ad_sin_a_in = sine_addr(sin_a);
      ad_sin_b_in = sine_addr(sin_b);
      ad_shp_a_in = shape_addr(shp_a);
      ad_shp_b_in = shape_addr(shp_b);
      ad_kind_in  = KIND_FLAT;
      ad_neg_a_in = 1'b0;
      ad_neg_b_in = 1'b0;
      ad_frac_in  = '0;
      ad_flat_in  = '0;

      unique case (in_mode_ff)
         MODE_SINE_LERP: begin
            ad_kind_in  = KIND_SINE;
            ad_neg_a_in = sin_a[SINE_IW-1];
            ad_neg_b_in = sin_b[SINE_IW-1];
            ad_frac_in  = in_phase_ff[31-SINE_IW -: FW];
         end
         MODE_SINE: begin
            // no blend: the second entry is weighted by zero
            ad_kind_in  = KIND_SINE;
            ad_neg_a_in = sin_a[SINE_IW-1];
            ad_neg_b_in = sin_b[SINE_IW-1];
         end
         MODE_TRIANGLE: begin
            unique case (in_phase_ff[31:30])
               2'd0: ad_flat_in = $signed({2'b00, tri_q});
               2'd1: ad_flat_in = SAMPLE_MAX - $signed({2'b00, tri_q});
               2'd2: ad_flat_in = -$signed({2'b00, tri_q});
               2'd3: ad_flat_in = $signed({2'b00, tri_q}) + SAMPLE_MIN;
            endcase
         end
         MODE_SQUARE: begin
            ad_flat_in = in_phase_ff[31] ? SAMPLE_MAX : SAMPLE_MIN;
         end
         MODE_RAMP_UP: begin
            ad_flat_in = ramp_hi[15] ? SAMPLE_MAX : $signed({1'b0, ramp_hi});
         end
         MODE_RAMP_DOWN: begin
            ad_flat_in = ramp_hi[15] ? 17'sd0 : SAMPLE_MAX - $signed({1'b0, ramp_hi});
         end
         MODE_SHAPE_LERP: begin
            ad_kind_in  = KIND_SHAPE;
            ad_neg_a_in = shp_a[SHAPE_IW-1];
            ad_neg_b_in = shp_b[SHAPE_IW-1];
            ad_frac_in  = in_phase_ff[31-SHAPE_IW -: FW];
         end
         MODE_UNUSED: begin
            ad_flat_in = '0;
         end
      endcase
   end

   // ---- stage 2: table read and sign ----
   logic                 rd_vld_ff;
   logic signed [16:0]   rd_v1_ff, rd_v1_in;
   logic signed [16:0]   rd_v2_ff, rd_v2_in;
   logic [FW-1:0]        rd_frac_ff;
   logic signed [16:0]   raw1, raw2;

   always_comb begin
      unique case (ad_kind_ff)
         KIND_SINE: begin
            raw1 = $signed({2'b00, sine_rom[ad_sin_a_ff]});
            raw2 = $signed({2'b00, sine_rom[ad_sin_b_ff]});
         end
         KIND_SHAPE: begin
            raw1 = $signed({2'b00, shape_rom_value(9'(ad_shp_a_ff))});
            raw2 = $signed({2'b00, shape_rom_value(9'(ad_shp_b_ff))});
         end
         default: begin
            raw1 = ad_flat_ff;
            raw2 = ad_flat_ff;
         end
      endcase
      rd_v1_in = ad_neg_a_ff ? -raw1 : raw1;
      rd_v2_in = ad_neg_b_ff ? -raw2 : raw2;
   end

   // ---- stage 3: blend multiply ----
   logic                 ml_vld_ff;
   logic signed [16:0]   ml_v1_ff;
   logic signed [PW-1:0] ml_prod_ff, ml_prod_in;
   logic signed [16:0]   diff;

   always_comb begin
      diff       = rd_v2_ff - rd_v1_ff;
      ml_prod_in = PW'(diff * $signed({1'b0, rd_frac_ff}));
   end

   // ---- stage 4: floor shift, add, output ----
   logic                 out_vld_ff;
   logic signed [15:0]   out_sample_ff, out_sample_in;
   logic signed [PW-1:0] shifted;
   logic signed [16:0]   total;

   always_comb begin
      shifted       = ml_prod_ff >>> FW;
      total         = ml_v1_ff + shifted[16:0];
      out_sample_in = total[15:0];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         ad_vld_ff  <= 1'b0;
         rd_vld_ff  <= 1'b0;
         ml_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= start & ~busy;
         ad_vld_ff  <= in_vld_ff;
         rd_vld_ff  <= ad_vld_ff;
         ml_vld_ff  <= rd_vld_ff;
         out_vld_ff <= ml_vld_ff;
      end
   end

   // data path
   always_ff @(posedge clock) begin
      in_mode_ff    <= req_mode;
      in_phase_ff   <= req_phase;
      ad_kind_ff    <= ad_kind_in;
      ad_sin_a_ff   <= ad_sin_a_in;
      ad_sin_b_ff   <= ad_sin_b_in;
      ad_shp_a_ff   <= ad_shp_a_in;
      ad_shp_b_ff   <= ad_shp_b_in;
      ad_neg_a_ff   <= ad_neg_a_in;
      ad_neg_b_ff   <= ad_neg_b_in;
      ad_frac_ff    <= ad_frac_in;
      ad_flat_ff    <= ad_flat_in;
      rd_v1_ff      <= rd_v1_in;
      rd_v2_ff      <= rd_v2_in;
      rd_frac_ff    <= ad_frac_ff;
      ml_v1_ff      <= rd_v1_ff;
      ml_prod_ff    <= ml_prod_in;
      out_sample_ff <= out_sample_in;
   end

   assign busy       = 1'b0;
   assign rsp_valid  = out_vld_ff;
   assign rsp_sample = out_sample_ff;

   // ---- assertions ----
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("request transfer did not give a response five cycles later");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("response without a matching request transfer");

   a_square : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(start && !busy, 5) && $past(req_mode, 5) == MODE_SQUARE)
      |-> rsp_sample == ($past(req_phase[31], 5) ? 16'sh7FFF : 16'sh8000))
      else $error("square sample does not follow the top phase bit");

endmodule
